// ===== sv/pjst_pkg.sv =====
// ----------------------------------------------------------------------------
// pjst_pkg
// Shared types and constants of the priority job slot table.
// ----------------------------------------------------------------------------
package pjst_pkg;

  localparam int SLOTS     = 16;
  localparam int ID_W      = 32;
  localparam int TAG_W     = 16;
  localparam int PRI_W     = 2;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int COUNT_W   = $clog2(SLOTS + 1);

  localparam logic [PRI_W-1:0] PRI_MAX = PRI_W'(3);

  localparam logic [ACT_W-1:0] ACT_SUBMIT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [COUNT_W-1:0] pending_jobs;
    logic               is_done;
    logic [PRI_W-1:0]   popped_priority;
    logic [TAG_W-1:0]   popped_tag;
    logic [ID_W-1:0]    job_id;
    logic               status;
  } result_t;

  localparam int RES_W    = $bits(result_t);
  localparam int IN_FLD_W = TAG_W + PRI_W + ID_W;
  localparam int S_DATA_W = ((IN_FLD_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== sv/pjst_ram.sv =====
// ----------------------------------------------------------------------------
// pjst_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pjst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/priority_job_slot_table_top.sv =====
// ----------------------------------------------------------------------------
// priority_job_slot_table_top
// Table of pending jobs: submit, pop by priority, query by id.
//
// Usage:
//   s_* carries one command beat: s_tuser holds the action (submit, pop,
//   query), s_tdata the tag, priority and query id. Every command gives one
//   result beat on m_*: status, job id, popped tag and priority, done flag
//   and the pending count after the command. cfg_* writes the running flag;
//   submits are refused while it is low. cfg_ready is always high.
//   Each command scans the slot table one entry per cycle through the single
//   read port of the slot RAM, then passes the drain and done states before
//   its result; a new command is taken only once the last is back in idle.
//   The result register lets the next command start while a result waits;
//   with the receiver stalled, a second finished result holds in the
//   sequencer and s_tready stays low until m_tready frees the register.
//   Reset empties the table, clears running, sets the next id to 1 and
//   drops any pending result. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module priority_job_slot_table_top
  import pjst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // job_tag, job_priority, query_id
  input  logic [ACT_W-1:0]    s_tuser,  // action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // status, job_id, popped_tag,
                                        // popped_priority, is_done, pending_jobs
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data  // running
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state;
  logic               running;
  logic [SLOTS-1:0]   valid;
  logic [COUNT_W-1:0] count;
  logic [ID_W-1:0]    id_ctr;
  logic [ID_W-1:0]    id_ctr_next;

  logic [ACT_W-1:0]   act;
  logic [TAG_W-1:0]   tag;
  logic [PRI_W-1:0]   pri;
  logic [ID_W-1:0]    qid;

  logic [IDX_W-1:0]   scan_idx;
  logic               eval_en;
  logic [IDX_W-1:0]   eval_idx;
  logic               found;
  logic               hit;
  logic [IDX_W-1:0]   pick_idx;
  slot_entry_t        best;
  slot_entry_t        rd;
  slot_entry_t        wr;

  logic               advance;
  logic               sub_ok;
  logic               ram_we;
  result_t            res;
  result_t            res_reg;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign advance   = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign sub_ok    = running && (count < COUNT_W'(SLOTS)) && found;
  assign ram_we    = advance && (act == ACT_SUBMIT) && sub_ok;

  assign id_ctr_next = (id_ctr + 1'b1 == '0) ? ID_W'(1) : id_ctr + 1'b1;

  always_comb begin
    wr.id  = id_ctr;
    wr.pri = (pri > PRI_MAX) ? PRI_MAX : pri;
    wr.tag = tag;
  end

  pjst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pick_idx),
    .wdata(wr),
    .raddr(scan_idx),
    .rdata(rd)
  );

  always_comb begin
    res = '0;
    res.pending_jobs = count;
    unique case (act)
      ACT_SUBMIT: begin
        if (sub_ok) begin
          res.job_id       = id_ctr;
          res.pending_jobs = count + 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      ACT_POP: begin
        if (found) begin
          res.job_id          = best.id;
          res.popped_tag      = best.tag;
          res.popped_priority = best.pri;
          res.pending_jobs    = count - 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      ACT_QUERY: begin
        res.is_done = !hit;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      running  <= 1'b0;
      valid    <= '0;
      count    <= '0;
      id_ctr   <= ID_W'(1);
      m_tvalid <= 1'b0;
      eval_en  <= 1'b0;
      found    <= 1'b0;
      hit      <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        running <= cfg_data;
      end
      eval_en  <= (state == ST_SCAN);
      eval_idx <= scan_idx;
      if (m_tready && !advance) begin
        m_tvalid <= 1'b0;
      end

      if (eval_en) begin
        unique case (act)
          ACT_SUBMIT: begin
            if (!valid[eval_idx] && !found) begin
              found    <= 1'b1;
              pick_idx <= eval_idx;
            end
          end
          ACT_POP: begin
            if (valid[eval_idx] && (!found || rd.pri > best.pri)) begin
              found    <= 1'b1;
              pick_idx <= eval_idx;
              best     <= rd;
            end
          end
          ACT_QUERY: begin
            if (valid[eval_idx] && rd.id == qid) begin
              hit <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act      <= s_tuser;
            tag      <= s_tdata[TAG_W-1:0];
            pri      <= s_tdata[TAG_W +: PRI_W];
            qid      <= s_tdata[TAG_W+PRI_W +: ID_W];
            found    <= 1'b0;
            hit      <= 1'b0;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx == IDX_W'(SLOTS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (advance) begin
            res_reg  <= res;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            if (act == ACT_SUBMIT && sub_ok) begin
              valid[pick_idx] <= 1'b1;
              count           <= count + 1'b1;
              id_ctr          <= id_ctr_next;
            end else if (act == ACT_POP && found) begin
              valid[pick_idx] <= 1'b0;
              count           <= count - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(M_DATA_W - RES_W){1'b0}}, res_reg};

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(valid))
    else $error("pending count differs from occupied slots");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    id_ctr != '0)
    else $error("id counter holds zero");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && act == ACT_POP && found) |-> valid[pick_idx])
    else $error("pop picked an empty slot");

  a_submit_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && act == ACT_SUBMIT && count < COUNT_W'(SLOTS))
      |-> (found && !valid[pick_idx]))
    else $error("submit found no free slot with room left");

endmodule
